// ===== hdl/msht_pkg.sv =====
// Shared types and constants for the mark-and-sweep handle table.
// Holds table sizing, operation and status codes, the controller states
// and the per-cell control word. Depends on nothing.
`default_nettype none

package msht_pkg;

  // Table depth and derived widths
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Counts are carried at the width of the entry_count field
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_COUNT = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_COUNT = 2'd1,
    S_SWEEP = 2'd2,
    S_RESP  = 2'd3
  } state_e;

  // Control word driven into each cell of the chain
  typedef struct packed {
    logic load;     // write the key as a new unmarked entry
    logic mark_en;  // compare the key and set the mark on a hit
    logic clr;      // clear the mark of a kept entry
    logic shift;    // take entry and mark from the right-hand neighbor
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/msht_if.sv =====
// Handshake channels for the mark-and-sweep handle table.
// One interface for command words, one for result words.
// Depends on msht_pkg for field widths.
`default_nettype none

interface msht_in_if;
  logic                          valid;
  logic                          ready;
  logic [msht_pkg::OP_W-1:0]     op;
  logic [msht_pkg::HANDLE_W-1:0] handle;

  modport source (output valid, output op, output handle, input ready);
  modport sink   (input valid, input op, input handle, output ready);
endinterface

interface msht_out_if;
  logic                          valid;
  logic                          ready;
  logic [msht_pkg::STATUS_W-1:0] status;
  logic                          freed_valid;
  logic [msht_pkg::HANDLE_W-1:0] freed_handle;
  logic                          last;
  logic [msht_pkg::CNT_W-1:0]    entry_count;
  logic [msht_pkg::CNT_W-1:0]    swept_count;

  modport source (output valid, output status, output freed_valid, output freed_handle,
                  output last, output entry_count, output swept_count, input ready);
  modport sink   (input valid, input status, input freed_valid, input freed_handle,
                  input last, input entry_count, input swept_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/msht_cell.sv =====
// One cell of the handle chain: a stored handle and its mark bit.
// Loads, compares, clears or takes its right-hand neighbor's entry.
// Depends on msht_pkg.
`default_nettype none

module msht_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire msht_pkg::cell_ctl_t ctl_i,
  input  wire msht_pkg::handle_t   key_i,
  input  wire msht_pkg::handle_t   nxt_handle_i,
  input  wire logic                nxt_mark_i,
  output msht_pkg::handle_t        handle_o,
  output logic                     mark_o,
  output logic                     hit_o
);

  msht_pkg::handle_t handle_q, handle_d;
  logic              mark_q, mark_d;

  // Compare the key against the stored handle
  assign hit_o = (handle_q == key_i);

  // Select the next handle
  always_comb begin
    handle_d = handle_q;
    if (ctl_i.load) begin
      handle_d = key_i;
    end else if (ctl_i.shift) begin
      handle_d = nxt_handle_i;
    end
  end

  // Select the next mark
  always_comb begin
    mark_d = mark_q;
    priority if (ctl_i.load) begin
      mark_d = 1'b0;
    end else if (ctl_i.shift) begin
      mark_d = nxt_mark_i;
    end else if (ctl_i.mark_en && hit_o) begin
      mark_d = 1'b1;
    end else if (ctl_i.clr) begin
      mark_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

  assign handle_o = handle_q;
  assign mark_o   = mark_q;

endmodule

`default_nettype wire

// ===== hdl/mark_sweep_handle_table.sv =====
// Mark-and-sweep handle table: a chain of CAPACITY cells under one controller.
// Allocate, mark and count take one word; the command is registered into the
// response state, which loads the one result word into the result register
// once that register is free. Mark compares all occupied cells in parallel.
// A sweep keeps the input busy until compaction is done, plus any time the
// result side stalls, and a sweep that frees nothing ends with one result word
// from the response state: a first pass walks the mark bits one cell per cycle
// to learn how many entries survive, then a second pass examines one entry per
// cycle, a freed one only when the result slot is free, clearing the mark of a
// kept entry or emitting a freed handle while the cells to its right shift left
// by one place to close the gap. One word is handled at a time; ready is high
// only while the controller is idle. A result register sits at the output, so
// a finished word may wait there while the next command is taken.
// Depends on msht_pkg, msht_if and msht_cell.
`default_nettype none

module mark_sweep_handle_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  msht_in_if.sink   in_i,
  msht_out_if.source out_o
);

  localparam int unsigned CAP = msht_pkg::CAPACITY;
  localparam int unsigned CW  = msht_pkg::CNT_W;
  localparam int unsigned IW  = msht_pkg::IDX_W;

  // Controller state and counters
  msht_pkg::state_e  state_q, state_d;
  msht_pkg::cnt_t    fill_q, fill_d;
  msht_pkg::cnt_t    j_q, j_d;          // counting pass position
  msht_pkg::cnt_t    keep_q, keep_d;    // survivors counted in the first pass
  msht_pkg::cnt_t    wr_q, wr_d;        // next unexamined cell in compaction
  msht_pkg::cnt_t    rem_q, rem_d;      // entries left to examine
  msht_pkg::cnt_t    emitted_q, emitted_d;
  msht_pkg::cnt_t    nfreed_q, nfreed_d;
  msht_pkg::status_e status_q, status_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  msht_pkg::status_e out_status_q, out_status_d;
  logic              out_freed_q, out_freed_d;
  msht_pkg::handle_t out_handle_q, out_handle_d;
  logic              out_last_q, out_last_d;
  msht_pkg::cnt_t    out_entry_q, out_entry_d;
  msht_pkg::cnt_t    out_swept_q, out_swept_d;

  // Chain signals
  msht_pkg::cell_ctl_t cell_ctl    [CAP];
  msht_pkg::handle_t   cell_handle [CAP];
  logic [CAP-1:0]      cell_mark;
  logic [CAP-1:0]      cell_hit;
  logic [CAP-1:0]      cell_occ;

  // Control strobes
  logic alloc_wr, mark_go, keep_step, free_step, out_load;
  logic in_acc, slot_free, found;
  logic sel_mark_j, sel_mark_w;
  msht_pkg::handle_t sel_handle_w;
  msht_pkg::op_e     in_op;

  assign in_op     = msht_pkg::op_e'(in_i.op);
  assign in_i.ready = (state_q == msht_pkg::S_IDLE);
  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign found     = |(cell_hit & cell_occ);

  assign sel_mark_j   = cell_mark[j_q[IW-1:0]];
  assign sel_mark_w   = cell_mark[wr_q[IW-1:0]];
  assign sel_handle_w = cell_handle[wr_q[IW-1:0]];

  // Build the chain; each cell takes its right-hand neighbor on a shift
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    msht_pkg::handle_t nxt_handle;
    logic              nxt_mark;

    if (i < CAP - 1) begin : g_mid
      assign nxt_handle = cell_handle[i+1];
      assign nxt_mark   = cell_mark[i+1];
    end else begin : g_end
      assign nxt_handle = '0;
      assign nxt_mark   = 1'b0;
    end

    assign cell_occ[i]         = CW'(i) < fill_q;
    assign cell_ctl[i].load    = alloc_wr && (CW'(i) == fill_q);
    assign cell_ctl[i].mark_en = mark_go && cell_occ[i];
    assign cell_ctl[i].clr     = keep_step && (CW'(i) == wr_q);
    assign cell_ctl[i].shift   = free_step && (CW'(i) >= wr_q);

    msht_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[i]),
      .key_i        (in_i.handle),
      .nxt_handle_i (nxt_handle),
      .nxt_mark_i   (nxt_mark),
      .handle_o     (cell_handle[i]),
      .mark_o       (cell_mark[i]),
      .hit_o        (cell_hit[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msht_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (in_op == msht_pkg::OP_SWEEP) ? msht_pkg::S_COUNT : msht_pkg::S_RESP;
        end
      end
      msht_pkg::S_COUNT: begin
        if (j_q == fill_q) begin
          state_d = msht_pkg::S_SWEEP;
        end
      end
      msht_pkg::S_SWEEP: begin
        if (rem_q == '0) begin
          state_d = (nfreed_q == '0) ? msht_pkg::S_RESP : msht_pkg::S_IDLE;
        end
      end
      msht_pkg::S_RESP: begin
        if (slot_free) begin
          state_d = msht_pkg::S_IDLE;
        end
      end
      default: state_d = msht_pkg::S_IDLE;
    endcase
  end

  // Datapath control and result formation
  always_comb begin
    fill_d       = fill_q;
    j_d          = j_q;
    keep_d       = keep_q;
    wr_d         = wr_q;
    rem_d        = rem_q;
    emitted_d    = emitted_q;
    nfreed_d     = nfreed_q;
    status_d     = status_q;
    alloc_wr     = 1'b0;
    mark_go      = 1'b0;
    keep_step    = 1'b0;
    free_step    = 1'b0;
    out_load     = 1'b0;
    out_status_d = msht_pkg::ST_OK;
    out_freed_d  = 1'b0;
    out_handle_d = '0;
    out_last_d   = 1'b1;
    out_entry_d  = fill_q;
    out_swept_d  = '0;

    unique case (state_q)
      msht_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            msht_pkg::OP_ALLOC: begin
              if (fill_q == CW'(CAP)) begin
                status_d = msht_pkg::ST_FULL;
              end else begin
                alloc_wr = 1'b1;
                fill_d   = fill_q + 1'b1;
                status_d = msht_pkg::ST_OK;
              end
            end
            msht_pkg::OP_MARK: begin
              mark_go  = 1'b1;
              status_d = found ? msht_pkg::ST_OK : msht_pkg::ST_NOT_FOUND;
            end
            msht_pkg::OP_SWEEP: begin
              j_d      = '0;
              keep_d   = '0;
              status_d = msht_pkg::ST_OK;
            end
            msht_pkg::OP_COUNT: begin
              status_d = msht_pkg::ST_OK;
            end
            default: status_d = msht_pkg::ST_OK;
          endcase
        end
      end

      // Count survivors one cell per cycle
      msht_pkg::S_COUNT: begin
        if (j_q == fill_q) begin
          nfreed_d  = fill_q - keep_q;
          rem_d     = fill_q;
          wr_d      = '0;
          emitted_d = '0;
        end else begin
          keep_d = keep_q + CW'(sel_mark_j);
          j_d    = j_q + 1'b1;
        end
      end

      // Compact: keep in place or emit and close the gap
      msht_pkg::S_SWEEP: begin
        if (rem_q == '0) begin
          fill_d = keep_q;
        end else if (sel_mark_w) begin
          keep_step = 1'b1;
          wr_d      = wr_q + 1'b1;
          rem_d     = rem_q - 1'b1;
        end else if (slot_free) begin
          free_step    = 1'b1;
          out_load     = 1'b1;
          out_freed_d  = 1'b1;
          out_handle_d = sel_handle_w;
          out_last_d   = (CW'(emitted_q + 1'b1) == nfreed_q);
          out_entry_d  = keep_q;
          out_swept_d  = out_last_d ? nfreed_q : '0;
          rem_d        = rem_q - 1'b1;
          emitted_d    = emitted_q + 1'b1;
        end
      end

      // Single result word
      msht_pkg::S_RESP: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_status_d = status_q;
        end
      end

      default: ;
    endcase
  end

  // Hold or drop the result word
  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msht_pkg::S_IDLE;
      fill_q      <= '0;
      j_q         <= '0;
      keep_q      <= '0;
      wr_q        <= '0;
      rem_q       <= '0;
      emitted_q   <= '0;
      nfreed_q    <= '0;
      status_q    <= msht_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      j_q         <= j_d;
      keep_q      <= keep_d;
      wr_q        <= wr_d;
      rem_q       <= rem_d;
      emitted_q   <= emitted_d;
      nfreed_q    <= nfreed_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_freed_q  <= out_freed_d;
      out_handle_q <= out_handle_d;
      out_last_q   <= out_last_d;
      out_entry_q  <= out_entry_d;
      out_swept_q  <= out_swept_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.freed_valid  = out_freed_q;
  assign out_o.freed_handle = out_handle_q;
  assign out_o.last         = out_last_q;
  assign out_o.entry_count  = out_entry_q;
  assign out_o.swept_count  = out_swept_q;

  // Checks
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAP))
    else $error("fill count beyond capacity");

  a_sweep_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msht_pkg::S_SWEEP |->
      ({1'b0, wr_q} + {1'b0, emitted_q} + {1'b0, rem_q}) == {1'b0, fill_q})
    else $error("compaction counters out of balance");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msht_pkg::S_SWEEP |-> emitted_q <= nfreed_q)
    else $error("more entries freed than counted");

  a_tail_unmarked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msht_pkg::S_IDLE |-> (cell_mark & ~cell_occ) == '0)
    else $error("mark set on an unoccupied cell");

endmodule

`default_nettype wire

// ===== bench/tb_mark_sweep_handle_table.sv =====
// Self-checking bench for the mark-and-sweep handle table: drives command words,
// predicts every result word from its own copy of the table, and checks each one.
// Depends on msht_pkg, msht_if and mark_sweep_handle_table from the hdl folder.
`default_nettype none

module tb_mark_sweep_handle_table;
  import msht_pkg::*;

  localparam int unsigned RANDOM_CMDS  = 150;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef struct {
    op_e     op;
    handle_t handle;
    bit      wait_idle;  // hold this word back until all results are in
  } command_t;

  typedef struct {
    status_e status;
    logic    freed_valid;
    handle_t freed_handle;
    logic    last;
    cnt_t    entry_count;
    cnt_t    swept_count;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n;

  msht_in_if  cmd_if ();
  msht_out_if res_if ();

  mark_sweep_handle_table i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always #5 clk = ~clk;

  // Predicted table contents
  handle_t table_handles [CAPACITY];
  bit      table_marks   [CAPACITY];
  int      table_fill;

  command_t     pending_cmds   [$];
  result_word_t expected_words [$];

  int cmds_accepted;
  int words_checked;
  int handles_freed;
  int full_reports;
  int miss_reports;
  int mismatches;
  int burst_left;
  int gap_left;
  int ready_mode;
  int ready_phase;
  int quiet_cycles;
  command_t     next_cmd;
  result_word_t want;

  // Apply one command to the predicted table and queue the words it yields
  function automatic void apply_table_cmd(op_e op, handle_t h);
    handle_t      freed_list [$];
    result_word_t w;
    int           keep;
    bit           hit;
    w = '{status: ST_OK, freed_valid: 1'b0, freed_handle: '0, last: 1'b1,
          entry_count: '0, swept_count: '0};
    keep = 0;
    hit  = 1'b0;
    case (op)
      OP_ALLOC: begin
        if (table_fill >= CAPACITY) begin
          w.status = ST_FULL;
        end else begin
          table_handles[table_fill] = h;
          table_marks[table_fill]   = 1'b0;
          table_fill++;
        end
      end
      OP_MARK: begin
        for (int i = 0; i < table_fill; i++) begin
          if (table_handles[i] == h) begin
            table_marks[i] = 1'b1;
            hit = 1'b1;
          end
        end
        if (!hit) w.status = ST_NOT_FOUND;
      end
      OP_SWEEP: begin
        for (int i = 0; i < table_fill; i++) begin
          if (table_marks[i]) begin
            table_handles[keep] = table_handles[i];
            table_marks[keep]   = 1'b0;
            keep++;
          end else begin
            freed_list.push_back(table_handles[i]);
          end
        end
        for (int i = keep; i < CAPACITY; i++) table_marks[i] = 1'b0;
        table_fill = keep;
      end
      default: ;
    endcase
    w.entry_count = cnt_t'(table_fill);
    if (op == OP_SWEEP && freed_list.size() != 0) begin
      foreach (freed_list[k]) begin
        w.freed_valid  = 1'b1;
        w.freed_handle = freed_list[k];
        w.last         = (k == freed_list.size() - 1);
        w.swept_count  = w.last ? cnt_t'(freed_list.size()) : '0;
        expected_words.push_back(w);
      end
    end else begin
      expected_words.push_back(w);
    end
  endfunction

  task automatic add_cmd(op_e op, handle_t h, bit wait_idle = 1'b0);
    command_t c;
    c.op        = op;
    c.handle    = h;
    c.wait_idle = wait_idle;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // Allocate a few handles, mark some of them, maybe count, then sweep
  task automatic add_collect_cycle(int n_alloc, bit hold_first);
    handle_t pool [$];
    handle_t h;
    int      n_mark;
    for (int i = 0; i < n_alloc; i++) begin
      if (pool.size() != 0 && $urandom_range(0, 3) == 0)
        h = pool[$urandom_range(0, pool.size() - 1)];
      else
        h = handle_t'($urandom);
      pool.push_back(h);
      add_cmd(OP_ALLOC, h, hold_first && i == 0);
    end
    n_mark = $urandom_range(0, n_alloc);
    for (int i = 0; i < n_mark; i++) begin
      if ($urandom_range(0, 4) == 0)
        add_cmd(OP_MARK, handle_t'($urandom));
      else
        add_cmd(OP_MARK, pool[$urandom_range(0, pool.size() - 1)]);
    end
    if ($urandom_range(0, 1) == 0) add_cmd(OP_COUNT, handle_t'($urandom));
    add_cmd(OP_SWEEP, handle_t'($urandom));
  endtask

  // Stimulus: directed corner cases, then random sequences
  initial begin
    int target;
    int kind;
    cmd_if.valid  = 1'b0;
    cmd_if.op     = OP_COUNT;
    cmd_if.handle = '0;
    res_if.ready  = 1'b0;
    rst_n         = 1'b0;
    table_fill    = 0;
    foreach (table_marks[i]) table_marks[i] = 1'b0;

    // Empty table: count, sweep with nothing to free, mark that misses
    add_cmd(OP_COUNT, 16'h0000);
    add_cmd(OP_SWEEP, 16'hA5A5);
    add_cmd(OP_MARK,  16'hFFFF);
    // Extreme handles and a duplicate pair
    add_cmd(OP_ALLOC, 16'h0000);
    add_cmd(OP_ALLOC, 16'hFFFF);
    add_cmd(OP_ALLOC, 16'hFFFF);
    add_cmd(OP_ALLOC, 16'h1234);
    // Mark both duplicates, mark again while marked, then a miss
    add_cmd(OP_MARK,  16'hFFFF);
    add_cmd(OP_MARK,  16'hFFFF);
    add_cmd(OP_MARK,  16'h5555);
    add_cmd(OP_COUNT, 16'hFFFF);
    // Free the unmarked pair, then a sweep where everything survives
    add_cmd(OP_SWEEP, 16'hFFFF);
    add_cmd(OP_MARK,  16'hFFFF);
    add_cmd(OP_SWEEP, 16'h0000);
    add_cmd(OP_SWEEP, 16'h0000);
    add_cmd(OP_COUNT, 16'h0000);

    target = pending_cmds.size() + RANDOM_CMDS;

    // Fill past capacity once, quiet bench first
    for (int i = 0; i < CAPACITY + 2; i++)
      add_cmd(OP_ALLOC, handle_t'($urandom_range(0, 15)), i == 0);
    for (int i = 0; i < 6; i++) add_cmd(OP_MARK, handle_t'($urandom_range(0, 15)));
    add_cmd(OP_SWEEP, handle_t'($urandom));

    while (pending_cmds.size() < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        add_collect_cycle($urandom_range(1, 12), $urandom_range(0, 4) == 0);
      end else if (kind < 14) begin
        add_collect_cycle(CAPACITY + 1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 5))
          add_cmd(op_e'($urandom_range(0, 3)), handle_t'($urandom));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands and %0d result words: %0d handles freed,",
             cmds_accepted, words_checked, handles_freed);
    $display("%0d allocates refused on a full table, %0d marks that missed.",
             full_reports, miss_reports);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Command driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        apply_table_cmd(op_e'(cmd_if.op), cmd_if.handle);
        cmds_accepted++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (pending_cmds.size() == 0 ||
                     (pending_cmds[0].wait_idle && expected_words.size() != 0)) begin
          cmd_if.valid <= 1'b0;
        end else begin
          next_cmd = pending_cmds.pop_front();
          cmd_if.valid  <= 1'b1;
          cmd_if.op     <= next_cmd.op;
          cmd_if.handle <= next_cmd.handle;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      ready_mode  = 0;
      ready_phase = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        words_checked++;
        if (res_if.freed_valid === 1'b1) handles_freed++;
        if (res_if.status === ST_FULL) full_reports++;
        if (res_if.status === ST_NOT_FOUND) miss_reports++;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("status",       16'(want.status),      16'(res_if.status));
          check_field("freed_valid",  16'(want.freed_valid), 16'(res_if.freed_valid));
          check_field("freed_handle", want.freed_handle,     res_if.freed_handle);
          check_field("last",         16'(want.last),        16'(res_if.last));
          check_field("entry_count",  16'(want.entry_count), 16'(res_if.entry_count));
          check_field("swept_count",  16'(want.swept_count), 16'(res_if.swept_count));
        end
      end
      // Switch stall behavior at the end of each phase: open, random, or sparse
      ready_phase++;
      if (ready_phase == 48) begin
        ready_phase = 0;
        ready_mode  = $urandom_range(0, 2);
      end
      case (ready_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 1) == 1);
        default: res_if.ready <= (ready_phase % 6 == 0);
      endcase
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_words.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/msht_pkg.sv
hdl/msht_if.sv
hdl/msht_cell.sv
hdl/mark_sweep_handle_table.sv
bench/tb_mark_sweep_handle_table.sv
